FILE: src/pcrs_pkg.sv
// Shared constants and types for the per-channel radio statistics table.
`default_nettype none
package pcrs_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_REPORT_WORDS = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W = 16;
  localparam int TICK_W = 16;
  localparam int STAT_W = 32;
  localparam int STAT_FIELDS = 6;
  localparam int SNAP_FIELDS = 4;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 336;

  localparam logic DIR_INPUT = 1'b1;
  localparam logic DIR_OUTPUT = 1'b0;
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // Layout of one statistics row.
  localparam logic [2:0] F_OUT_CNT = 3'd0;
  localparam logic [2:0] F_IN_CNT = 3'd1;
  localparam logic [2:0] F_OUT_TX = 3'd2;
  localparam logic [2:0] F_OUT_RX = 3'd3;
  localparam logic [2:0] F_IN_TX = 3'd4;
  localparam logic [2:0] F_IN_RX = 3'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] channel;
    logic [KEY_W-1:0] network;
  } key_wr_t;

endpackage
`default_nettype wire

FILE: src/pcrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/pcrs_alu.sv
// Shared 32-bit add/subtract unit used for counter updates and report deltas.
`default_nettype none
module pcrs_alu (
  input  wire pcrs_pkg::alu_op_t          op,
  input  wire logic [pcrs_pkg::STAT_W-1:0] a,
  input  wire logic [pcrs_pkg::STAT_W-1:0] b,
  output logic      [pcrs_pkg::STAT_W-1:0] y
);
  import pcrs_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/pcrs_keys.sv
// Entry key store with a single compare port for the sequential lookup.
`default_nettype none
module pcrs_keys (
  input  wire logic                          clk,
  input  wire pcrs_pkg::key_wr_t             wr,
  input  wire logic [pcrs_pkg::IDX_W-1:0]    rd_idx,
  input  wire logic                          match_net,
  input  wire logic [pcrs_pkg::KEY_W-1:0]    probe_channel,
  input  wire logic [pcrs_pkg::KEY_W-1:0]    probe_network,
  output logic                               hit,
  output logic      [pcrs_pkg::KEY_W-1:0]    rd_channel
);
  import pcrs_pkg::*;

  logic [KEY_W-1:0] key_channel [TABLE_ENTRIES];
  logic [KEY_W-1:0] key_network [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_channel[wr.idx] <= wr.channel;
      key_network[wr.idx] <= wr.network;
    end
  end

  always_comb begin
    rd_channel = key_channel[rd_idx];
    hit = (key_channel[rd_idx] == probe_channel) &&
          (!match_net || (key_network[rd_idx] == probe_network));
  end

endmodule
`default_nettype wire

FILE: src/per_channel_radio_stats_table.sv
// Per-channel radio statistics table: top level with the sequencer.
//
// Input words arrive on the s_ channel. s_tuser selects the request: a packet
// event (s_tdata carries direction, channel, network id, transmit and listen
// ticks) or a report request (s_tdata ignored). One word is handled at a time
// and s_tready is high only while the block is idle.
// A packet event scans the stored keys one entry per cycle with a single
// comparator. A hit reads the entry's statistics row from RAM; a miss
// allocates the next free entry with cleared counters. The count and the
// two tick sums are then updated through one shared adder, one field per
// cycle, and the row is written back. A miss on a full table is dropped.
// A report emits one word per allocated entry on the m_ channel, in
// allocation order, with m_tlast on the final one. Each entry goes through
// a RAM read, a load, four subtractions for the deltas and an output step. An
// empty table gives no word. Results sit in an output register; if the
// receiver stalls, the report pauses on the next entry until the register
// is taken. Reset empties the table and clears the network id match mode.
// The configuration register is written through cfg_wr_en; the user must
// write it only while idle, the block itself does not enforce this.
`default_nettype none
module per_channel_radio_stats_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_wr_data,    // match_network_id
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // direction[0], channel[16:1], network_id[32:17], tx_ticks[48:33],
  // listen_ticks[64:49], zero padding[71:65]
  input  wire logic [pcrs_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tuser,        // req_type
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // entry_channel[15:0], in_count[47:16], in_tx_total[79:48],
  // in_rx_total[111:80], in_tx_delta[143:112], in_rx_delta[175:144],
  // out_count[207:176], out_tx_total[239:208], out_rx_total[271:240],
  // out_tx_delta[303:272], out_rx_delta[335:304]
  output logic      [pcrs_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                   m_tlast         // last_entry
);
  import pcrs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_UPD,
    ST_WR,
    ST_REP_RD,
    ST_REP_LOAD,
    ST_REP_SUB,
    ST_REP_OUT
  } state_t;

  localparam int ROW_W = STAT_FIELDS * STAT_W;
  localparam int SNAP_W = SNAP_FIELDS * STAT_W;

  state_t              state;
  logic                match_net;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    scan;
  logic [1:0]          step;
  logic                dir;
  logic [KEY_W-1:0]    chan;
  logic [KEY_W-1:0]    net;
  logic [TICK_W-1:0]   tx;
  logic [TICK_W-1:0]   rx;
  logic [STAT_W-1:0]   row   [STAT_FIELDS];
  logic [STAT_W-1:0]   snap  [SNAP_FIELDS];
  logic [STAT_W-1:0]   delta [SNAP_FIELDS];

  logic                scan_end;
  logic                table_full;
  logic                alloc;
  logic                out_free;
  logic                rep_fire;
  logic                rep_last;
  logic [IDX_W-1:0]    idx;
  logic                key_hit;
  logic [KEY_W-1:0]    key_rd_channel;
  key_wr_t             key_wr;

  logic                stats_we;
  logic [ROW_W-1:0]    stats_wdata;
  logic [ROW_W-1:0]    stats_rdata;
  logic                snap_we;
  logic [IDX_W-1:0]    snap_waddr;
  logic [SNAP_W-1:0]   snap_wdata;
  logic [SNAP_W-1:0]   snap_rdata;

  alu_op_t             alu_op;
  logic [STAT_W-1:0]   alu_a;
  logic [STAT_W-1:0]   alu_b;
  logic [STAT_W-1:0]   alu_y;
  logic [2:0]          upd_fld;
  logic [2:0]          sum_fld;

  assign idx        = scan[IDX_W-1:0];
  assign s_tready   = (state == ST_IDLE);
  assign scan_end   = (scan == used);
  assign table_full = (used == CNT_W'(TABLE_ENTRIES));
  assign alloc      = (state == ST_SCAN) && scan_end && !table_full;
  assign out_free   = !m_tvalid || m_tready;
  assign rep_fire   = (state == ST_REP_OUT) && out_free;
  assign rep_last   = ((scan + CNT_W'(1)) == used);

  // Field selection for the shared adder.
  always_comb begin
    case (step)
      2'd0:    upd_fld = (dir == DIR_INPUT) ? F_IN_CNT : F_OUT_CNT;
      2'd1:    upd_fld = (dir == DIR_INPUT) ? F_IN_TX : F_OUT_TX;
      default: upd_fld = (dir == DIR_INPUT) ? F_IN_RX : F_OUT_RX;
    endcase
    sum_fld = F_OUT_TX + {1'b0, step};
    if (state == ST_REP_SUB) begin
      alu_op = ALU_SUB;
      alu_a  = row[sum_fld];
      alu_b  = snap[step];
    end else begin
      alu_op = ALU_ADD;
      alu_a  = row[upd_fld];
      case (step)
        2'd0:    alu_b = STAT_W'(1);
        2'd1:    alu_b = STAT_W'(tx);
        default: alu_b = STAT_W'(rx);
      endcase
    end
  end

  pcrs_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_comb begin
    key_wr.en      = alloc;
    key_wr.idx     = idx;
    key_wr.channel = chan;
    key_wr.network = net;
  end

  pcrs_keys u_keys (
    .clk           (clk),
    .wr            (key_wr),
    .rd_idx        (idx),
    .match_net     (match_net),
    .probe_channel (chan),
    .probe_network (net),
    .hit           (key_hit),
    .rd_channel    (key_rd_channel)
  );

  always_comb begin
    for (int i = 0; i < STAT_FIELDS; i++) begin
      stats_wdata[i*STAT_W +: STAT_W] = row[i];
    end
    for (int i = 0; i < SNAP_FIELDS; i++) begin
      snap_wdata[i*STAT_W +: STAT_W] = alloc ? '0 : row[F_OUT_TX + 3'(i)];
    end
  end

  assign stats_we   = (state == ST_WR);
  // A new entry gets a cleared snapshot row; its statistics row starts from
  // cleared counters and is written at the end of the update.
  assign snap_we    = alloc || rep_fire;
  assign snap_waddr = idx;

  pcrs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_stats_ram (
    .clk   (clk),
    .we    (stats_we),
    .waddr (idx),
    .wdata (stats_wdata),
    .raddr (idx),
    .rdata (stats_rdata)
  );

  pcrs_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (idx),
    .rdata (snap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      match_net <= 1'b0;
      used      <= '0;
      scan      <= '0;
      step      <= '0;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        match_net <= cfg_wr_data;
      end
      if (m_tready && !rep_fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dir  <= s_tdata[0];
            chan <= s_tdata[16:1];
            net  <= s_tdata[32:17];
            tx   <= s_tdata[48:33];
            rx   <= s_tdata[64:49];
            scan <= '0;
            if (s_tuser == REQ_REPORT) begin
              if (used != '0) begin
                state <= ST_REP_RD;
              end
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            if (table_full) begin
              state <= ST_IDLE;
            end else begin
              for (int i = 0; i < STAT_FIELDS; i++) begin
                row[i] <= '0;
              end
              used  <= used + CNT_W'(1);
              step  <= '0;
              state <= ST_UPD;
            end
          end else if (key_hit) begin
            state <= ST_LOAD;
          end else begin
            scan <= scan + CNT_W'(1);
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < STAT_FIELDS; i++) begin
            row[i] <= stats_rdata[i*STAT_W +: STAT_W];
          end
          step  <= '0;
          state <= ST_UPD;
        end
        ST_UPD: begin
          row[upd_fld] <= alu_y;
          step <= step + 2'd1;
          if (step == 2'd2) begin
            state <= ST_WR;
          end
        end
        ST_WR: begin
          state <= ST_IDLE;
        end
        ST_REP_RD: begin
          state <= ST_REP_LOAD;
        end
        ST_REP_LOAD: begin
          for (int i = 0; i < STAT_FIELDS; i++) begin
            row[i] <= stats_rdata[i*STAT_W +: STAT_W];
          end
          for (int i = 0; i < SNAP_FIELDS; i++) begin
            snap[i] <= snap_rdata[i*STAT_W +: STAT_W];
          end
          step  <= '0;
          state <= ST_REP_SUB;
        end
        ST_REP_SUB: begin
          delta[step] <= alu_y;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= ST_REP_OUT;
          end
        end
        ST_REP_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= rep_last;
            m_tdata  <= {delta[1], delta[0], row[F_OUT_RX], row[F_OUT_TX],
                         row[F_OUT_CNT], delta[3], delta[2], row[F_IN_RX],
                         row[F_IN_TX], row[F_IN_CNT], key_rd_channel};
            if (rep_last) begin
              state <= ST_IDLE;
            end else begin
              scan  <= scan + CNT_W'(1);
              state <= ST_REP_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (used == $past(used)) || (used == $past(used) + CNT_W'(1)))
    else $error("entry count moved by more than one allocation");

  a_valid_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_REP_OUT))
    else $error("result word raised outside a report");

  a_write_allocated: assert property (@(posedge clk) disable iff (rst)
    stats_we |-> (scan < used))
    else $error("statistics row written for an unallocated entry");

  a_report_span: assert property (@(posedge clk) disable iff (rst)
    rep_fire |-> (scan < CNT_W'(MAX_REPORT_WORDS)))
    else $error("report ran past the most words one report may give");
`endif

endmodule
`default_nettype wire
